>>> rtl/decimal_token_int32_parser_macros.svh
// ----------------------------------------------------------------------------
// decimal_token_int32_parser assertion macros
// shared concurrent assertion forms for the parser checker
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TOKEN_INT32_PARSER_MACROS_SVH
`define DECIMAL_TOKEN_INT32_PARSER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtp assertion failed");

// consequent must hold in the cycle after the antecedent
`define DTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtp assertion failed");

`endif

>>> rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// types and constants shared by the decimal token parser modules
// ----------------------------------------------------------------------------
package dtp_pkg;

    localparam int MAX_TOKEN_CHARS = 11;
    localparam int COUNT_WIDTH     = 16;
    localparam int LEN_LIMIT       = MAX_TOKEN_CHARS + 1;
    localparam int LEN_W           = $clog2(LEN_LIMIT + 1);
    localparam int MAG_W           = 37;
    localparam int VALUE_W         = 32;
    localparam int STATUS_W        = 2;
    localparam int INDEX_W         = 16;
    localparam int BYTE_W          = 8;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_FIELDS_W    = VALUE_W + STATUS_W + INDEX_W;
    localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // largest magnitudes that still fit int32
    localparam logic [MAG_W-1:0] POS_MAX = MAG_W'(64'd2147483647);
    localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(64'd2147483648);

    typedef enum logic [2:0] {
        CK_DIGIT,
        CK_PLUS,
        CK_MINUS,
        CK_SPACE,
        CK_OTHER
    } char_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_BAD_CHAR = 2'd2,
        ST_RANGE    = 2'd3
    } parse_status_t;

    typedef struct packed {
        char_kind_t  kind;
        logic [3:0]  digit;
        logic        last;
    } dtp_item_t;

endpackage

>>> rtl/dtp_front.sv
// ----------------------------------------------------------------------------
// dtp_front
// takes input bytes and sorts them into digit, sign, whitespace or other
// ----------------------------------------------------------------------------
module dtp_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dtp_pkg::IN_TDATA_W-1:0] s_axis_tdata, // text_byte
    input  logic                          s_axis_tlast,  // end_of_argument
    input  logic                          q_full,
    output logic                          q_push,
    output dtp_pkg::dtp_item_t            q_item
);
    import dtp_pkg::*;

    logic [BYTE_W-1:0] text_byte;
    logic [BYTE_W-1:0] digit_off;

    assign text_byte     = s_axis_tdata[BYTE_W-1:0];
    assign digit_off     = text_byte - CH_ZERO;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_item.last  = s_axis_tlast;
        q_item.digit = digit_off[3:0];
        if (text_byte inside {[CH_ZERO:CH_NINE]})
        begin
            q_item.kind = CK_DIGIT;
        end
        else if (text_byte inside {[CH_TAB:CH_CR], CH_SPACE})
        begin
            q_item.kind = CK_SPACE;
        end
        else if (text_byte == CH_PLUS)
        begin
            q_item.kind = CK_PLUS;
        end
        else if (text_byte == CH_MINUS)
        begin
            q_item.kind = CK_MINUS;
        end
        else
        begin
            q_item.kind = CK_OTHER;
        end
    end

endmodule

>>> rtl/dtp_queue.sv
// ----------------------------------------------------------------------------
// dtp_queue
// short queue of classified items between the front and back parts
// ----------------------------------------------------------------------------
module dtp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dtp_pkg::dtp_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output dtp_pkg::dtp_item_t head_item
);
    import dtp_pkg::*;

    dtp_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/dtp_back.sv
// ----------------------------------------------------------------------------
// dtp_back
// accumulates token digits, checks the token at its end and holds the result
// ----------------------------------------------------------------------------
module dtp_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  dtp_pkg::dtp_item_t              q_item,
    output logic                            q_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // number_value, parse_status, token_index, zero fill
    output logic [dtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dtp_pkg::*;

    logic                   inside_reg, inside_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   neg_reg, neg_next;
    logic                   stopped_reg, stopped_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   halted_reg, halted_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    parse_status_t          status_reg, status_next;
    logic [INDEX_W-1:0]     index_reg, index_next;

    logic                   is_space;
    logic                   take;
    logic                   finish;
    logic                   load;
    logic [MAG_W-1:0]       mag_acc;
    logic [VALUE_W-1:0]     mag_low;
    parse_status_t          status_calc;

    assign q_pop    = q_valid && (!out_valid_reg || m_axis_tready);
    assign is_space = (q_item.kind == CK_SPACE);
    assign take     = q_pop && !halted_reg && !is_space;
    // times ten as two shifts and an add
    assign mag_acc  = (mag_reg << 3) + (mag_reg << 1) + MAG_W'(q_item.digit);

    // token state after taking this byte
    always_comb
    begin
        inside_next  = inside_reg;
        len_next     = len_reg;
        neg_next     = neg_reg;
        stopped_next = stopped_reg;
        mag_next     = mag_reg;
        if (take)
        begin
            inside_next = 1'b1;
            if (len_reg < LEN_W'(LEN_LIMIT))
            begin
                len_next = len_reg + 1'b1;
            end
            if ((len_reg == '0) && (q_item.kind == CK_PLUS || q_item.kind == CK_MINUS))
            begin
                neg_next = (q_item.kind == CK_MINUS);
            end
            else if (q_item.kind == CK_DIGIT && !stopped_reg)
            begin
                if (len_next <= LEN_W'(MAX_TOKEN_CHARS))
                begin
                    mag_next = mag_acc;
                end
            end
            else
            begin
                stopped_next = 1'b1;
            end
        end
    end

    assign finish  = q_pop && !halted_reg && inside_next && (q_item.last || is_space);
    assign load    = finish;
    assign mag_low = mag_next[VALUE_W-1:0];

    always_comb
    begin
        if (len_next > LEN_W'(MAX_TOKEN_CHARS))
        begin
            status_calc = ST_TOO_LONG;
        end
        else if (stopped_next)
        begin
            status_calc = ST_BAD_CHAR;
        end
        else if (neg_next ? (mag_next > NEG_MAX) : (mag_next > POS_MAX))
        begin
            status_calc = ST_RANGE;
        end
        else
        begin
            status_calc = ST_OK;
        end
    end

    always_comb
    begin
        value_next     = value_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        count_next     = count_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (load)
        begin
            out_valid_next = 1'b1;
            status_next    = status_calc;
            index_next     = INDEX_W'(count_reg);
            if (status_calc == ST_OK)
            begin
                value_next = neg_next ? (~mag_low + 1'b1) : mag_low;
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                value_next  = '0;
                halted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            len_reg       <= '0;
            neg_reg       <= 1'b0;
            stopped_reg   <= 1'b0;
            mag_reg       <= '0;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                // token closed, start a fresh one
                inside_reg  <= 1'b0;
                len_reg     <= '0;
                neg_reg     <= 1'b0;
                stopped_reg <= 1'b0;
                mag_reg     <= '0;
            end
            else
            begin
                inside_reg  <= inside_next;
                len_reg     <= len_next;
                neg_reg     <= neg_next;
                stopped_reg <= stopped_next;
                mag_reg     <= mag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        index_reg  <= index_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({index_reg, status_reg, value_reg});

endmodule

>>> rtl/decimal_token_int32_parser.sv
// the closing byte is queued when accepted, its result registered when popped
// throughput: one byte per cycle; one queued item retired per cycle if not stalled
// s_axis_tready drops only when the two-entry queue is full behind a stalled output
// reset (rst_n low, asynchronous) clears the token state, valid count, halt flag
// and queue; after an error result no further results come until reset
// ----------------------------------------------------------------------------
// decimal_token_int32_parser
// parses whitespace separated decimal tokens from a byte stream into int32 values
// ----------------------------------------------------------------------------
module decimal_token_int32_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dtp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // text_byte
    input  logic                            s_axis_tlast,  // end_of_argument
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // number_value[31:0], parse_status[33:32], token_index[49:34], zero fill
    output logic [dtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dtp_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_valid;
    dtp_item_t front_item;
    dtp_item_t head_item;

    dtp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (front_item)
    );

    dtp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    dtp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> rtl/dtp_checker.sv
// ----------------------------------------------------------------------------
// dtp_checker
// port level checks on the decimal token parser, bound to the top level
// ----------------------------------------------------------------------------
`include "decimal_token_int32_parser_macros.svh"

module dtp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [dtp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dtp_pkg::*;

    logic out_err;
    logic out_take;
    logic in_take;

    assign out_err  = (m_axis_tdata[33:32] != ST_OK);
    assign out_take = m_axis_tvalid && m_axis_tready;
    assign in_take  = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || s_axis_tlast);

    // a waiting result holds until taken
    `DTP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // error results carry a zero value
    `DTP_ASSERT_SAME(a_err_zero, clk, rst_n, m_axis_tvalid && out_err, m_axis_tdata[31:0] == '0)
    // nothing follows a delivered error
    `DTP_ASSERT_NEXT(a_err_quiet, clk, rst_n, out_take && out_err, !m_axis_tvalid)
    // the zero fill bits stay zero while a result is valid or a nonzero or last input byte is taken
    `DTP_ASSERT_SAME(a_fill_zero, clk, rst_n, m_axis_tvalid || in_take, m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)

endmodule

bind decimal_token_int32_parser dtp_checker u_dtp_checker (.*);

>>> dv/tb_decimal_token_int32_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_token_int32_parser
// streams text bytes into the parser and compares every result item with a
// cycle-free prediction of the token parser, with and without random stalls on both sides
// ----------------------------------------------------------------------------
module tb_decimal_token_int32_parser;
    import dtp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 540;
    localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
    localparam logic [BYTE_W-1:0] CH_VT = 8'd11;
    localparam logic [BYTE_W-1:0] CH_FF = 8'd12;

    typedef struct {
        logic [VALUE_W-1:0] value;
        parse_status_t      status;
        logic [INDEX_W-1:0] index;
    } number_result_t;

    class token_scoreboard;
        bit                     in_token;
        bit                     negative;
        bit                     digits_stopped;
        bit                     halted;
        logic [LEN_W-1:0]       tok_len;
        logic [MAG_W-1:0]       magnitude;
        logic [COUNT_WIDTH-1:0] valid_count;
        number_result_t         expected_q[$];
        int                     errors;

        function new();
            clear_token();
            valid_count = '0;
            halted      = 1'b0;
            errors      = 0;
        endfunction

        function void clear_token();
            in_token       = 1'b0;
            negative       = 1'b0;
            digits_stopped = 1'b0;
            tok_len        = '0;
            magnitude      = '0;
        endfunction

        function bit is_space(logic [BYTE_W-1:0] b);
            return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted input item; queues the result it closes, if any
        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            number_result_t r;
            int unsigned    pos;
            if (halted)
                return;
            if (!is_space(b)) begin
                pos      = 32'(tok_len);
                in_token = 1'b1;
                if (tok_len < LEN_LIMIT)
                    tok_len++;
                if (pos == 0 && (b == CH_PLUS || b == CH_MINUS))
                    negative = (b == CH_MINUS);
                else if (b >= CH_ZERO && b <= CH_NINE && !digits_stopped) begin
                    // characters past the length limit no longer accumulate
                    if (tok_len <= MAX_TOKEN_CHARS)
                        magnitude = magnitude * 10 + MAG_W'(b - CH_ZERO);
                end
                else
                    digits_stopped = 1'b1;
            end
            if (in_token && (last || is_space(b))) begin
                if (tok_len > MAX_TOKEN_CHARS)
                    r.status = ST_TOO_LONG;
                else if (digits_stopped)
                    r.status = ST_BAD_CHAR;
                else if (negative ? (magnitude > NEG_MAX) : (magnitude > POS_MAX))
                    r.status = ST_RANGE;
                else
                    r.status = ST_OK;
                r.value = '0;
                if (r.status == ST_OK)
                    r.value = negative ? (VALUE_W'(0) - magnitude[VALUE_W-1:0])
                                       : magnitude[VALUE_W-1:0];
                r.index = valid_count[INDEX_W-1:0];
                if (r.status == ST_OK) begin
                    if (valid_count != '1)
                        valid_count++;
                end
                else
                    halted = 1'b1;
                expected_q.push_back(r);
                clear_token();
            end
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            number_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none actual value %0d status %0d index %0d",
                         $time, $signed(data[VALUE_W-1:0]), data[VALUE_W +: STATUS_W],
                         data[VALUE_W+STATUS_W +: INDEX_W]);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("number_value", longint'($signed(want.value)),
                        longint'($signed(data[VALUE_W-1:0])));
            check_field("parse_status", longint'(want.status),
                        longint'(data[VALUE_W +: STATUS_W]));
            check_field("token_index", longint'(want.index),
                        longint'(data[VALUE_W+STATUS_W +: INDEX_W]));
            check_field("zero_fill", 0, longint'(data[OUT_TDATA_W-1:OUT_FIELDS_W]));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    token_scoreboard   sb = new();
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                bytes_sent = 0;
    int                cycle_count = 0;
    logic [BYTE_W-1:0] token_text[$];

    decimal_token_int32_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit last_on_final);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_on_final && (i == s.len() - 1));
    endtask

    // hold the sender off until every queued result has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] pick_space();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CH_SPACE : CH_TAB + BYTE_W'(k);
    endfunction

    // decimal digits, most significant first, zero padded to width
    function automatic void append_decimal(longint unsigned mag, int width);
        logic [BYTE_W-1:0] digs[$];
        do begin
            digs.push_front(CH_ZERO + BYTE_W'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        while (digs.size() < width)
            digs.push_front(CH_ZERO);
        foreach (digs[i])
            token_text.push_back(digs[i]);
    endfunction

    // token is closed either by tlast on its final char or by a whitespace item
    task automatic send_token_text();
        bit end_on_last;
        end_on_last = ($urandom_range(3) == 0);
        while ($urandom_range(4) == 0)
            send_byte(pick_space(), $urandom_range(3) == 0);
        foreach (token_text[i])
            send_byte(token_text[i], end_on_last && (i == token_text.size() - 1));
        if (!end_on_last)
            send_byte(pick_space(), $urandom_range(3) == 0);
        token_text.delete();
    endtask

    task automatic send_random_number();
        longint          val;
        longint unsigned mag;
        int              pick;
        int              room;
        int              width;
        token_text.delete();
        pick = $urandom_range(19);
        if (pick == 0)
            token_text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        else begin
            case (pick)
                1:       val = -64'sd2147483648;
                2:       val = 64'sd2147483647;
                3, 4, 5: val = longint'($urandom_range(99));
                6, 7:    val = -longint'($urandom_range(9999));
                default: val = longint'(int'($urandom()));
            endcase
            if (val < 0) begin
                token_text.push_back(CH_MINUS);
                mag = -val;
            end
            else begin
                mag = val;
                case ($urandom_range(3))
                    0:       token_text.push_back(CH_PLUS);
                    1:       if (val == 0) token_text.push_back(CH_MINUS);
                    default: ;
                endcase
            end
            room  = MAX_TOKEN_CHARS - token_text.size();
            width = ($urandom_range(3) == 0) ? int'($urandom_range(room, 1)) : 0;
            append_decimal(mag, width);
        end
        send_token_text();
    endtask

    // one token that ends in an error; the parser stays silent afterwards
    task automatic send_error_token();
        int                kind;
        int                bad_pos;
        longint unsigned   lim;
        logic [BYTE_W-1:0] b;
        token_text.delete();
        kind = $urandom_range(2);
        if (kind == 0) begin
            repeat ($urandom_range(20, MAX_TOKEN_CHARS + 1)) begin
                do
                    b = BYTE_W'($urandom_range(255));
                while (sb.is_space(b));
                token_text.push_back(b);
            end
        end
        else if (kind == 1) begin
            if ($urandom_range(1))
                token_text.push_back(CH_MINUS);
            append_decimal(64'($urandom_range(999999)), 0);
            bad_pos = $urandom_range(token_text.size());
            do
                b = BYTE_W'($urandom_range(255));
            while (sb.is_space(b) || (b >= CH_ZERO && b <= CH_NINE) ||
                   (bad_pos == 0 && (b == CH_PLUS || b == CH_MINUS)));
            token_text.insert(bad_pos, b);
        end
        else begin
            lim = 64'd2147483647;
            if ($urandom_range(1)) begin
                token_text.push_back(CH_MINUS);
                lim = 64'd2147483648;
            end
            else if ($urandom_range(1))
                token_text.push_back(CH_PLUS);
            if ($urandom_range(1))
                append_decimal(lim + 1 + 64'($urandom_range(9)), 0);
            else
                append_decimal(lim + 1 + 64'($urandom()), 0);
        end
        send_token_text();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 75;
        // int32 extremes, every whitespace kind, lone signs, tlast on a blank
        send_text("-2147483648", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_text("2147483647", 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_text("+", 1'b0);
        send_byte(CH_VT, 1'b0);
        send_text("-", 1'b1);
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_FF, 1'b0);
        send_byte(CH_CR, 1'b1);
        send_text("7", 1'b0);
        send_byte(CH_LF, 1'b0);
        send_text("9", 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 18; recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            bytes_sent = 0;
            while (bytes_sent < PHASE_ITEMS)
                send_random_number();
            drain_results();
        end

        send_idle_pct = 10;
        recv_idle_pct = 30;
        send_error_token();
        repeat (40)
            send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> decimal_token_int32_parser.f
+incdir+rtl
rtl/dtp_pkg.sv
rtl/dtp_front.sv
rtl/dtp_queue.sv
rtl/dtp_back.sv
rtl/decimal_token_int32_parser.sv
rtl/dtp_checker.sv
dv/tb_decimal_token_int32_parser.sv
